FILE: src/time_ordered_ready_queue_defines.svh
// ----------------------------------------------------------------------------
// Time-ordered ready queue assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef TIME_ORDERED_READY_QUEUE_DEFINES_SVH
`define TIME_ORDERED_READY_QUEUE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TORQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define TORQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/torq_pkg.sv
// ----------------------------------------------------------------------------
// Time-ordered ready queue package
// Sizes, operation and status codes, field layout and controller interface.
// ----------------------------------------------------------------------------
package torq_pkg;

   localparam int CAPACITY       = 16;
   localparam int ID_BITS        = 8;
   localparam int TIME_BITS      = 32;
   localparam int SLOT_BITS      = $clog2(CAPACITY);
   localparam int CNT_BITS       = $clog2(CAPACITY + 1);

   localparam int OP_BITS        = 2;
   localparam int ST_BITS        = 3;
   localparam int EXT_ID_BITS    = 8;
   localparam int COUNT_OUT_BITS = 5;

   localparam int REQ_USER_BITS  = OP_BITS;
   localparam int REQ_USED_BITS  = EXT_ID_BITS + 2 * TIME_BITS + 1;
   localparam int REQ_DATA_BITS  = ((REQ_USED_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS  = ST_BITS;
   localparam int RSP_USED_BITS  = EXT_ID_BITS + 2 * TIME_BITS + COUNT_OUT_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_USED_BITS;

   localparam logic [OP_BITS-1:0] OP_INSERT   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_DISPATCH = 2'd2;
   localparam logic [OP_BITS-1:0] OP_COMPLETE = 2'd3;

   localparam logic [ST_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [ST_BITS-1:0] ST_EMPTY    = 3'd1;
   localparam logic [ST_BITS-1:0] ST_FULL     = 3'd2;
   localparam logic [ST_BITS-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [ST_BITS-1:0] ST_NOCUR    = 3'd4;

   typedef struct packed {
      logic capture;
      logic scan_read;
      logic commit;
   } torq_cmd_type;

   typedef struct packed {
      logic last_slot;
   } torq_stat_type;

   function automatic logic earlier(input logic [TIME_BITS-1:0] ta,
                                    input logic [ID_BITS-1:0]   ia,
                                    input logic [TIME_BITS-1:0] tb,
                                    input logic [ID_BITS-1:0]   ib);
      return (ta != tb) ? (ta < tb) : (ia < ib);
   endfunction

endpackage

FILE: src/torq_ctrl.sv
// ----------------------------------------------------------------------------
// Time-ordered ready queue controller
// Sequences capture, slot scan, drain and commit for each request.
// ----------------------------------------------------------------------------
module torq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output torq_pkg::torq_cmd_type  cmd,
   input  torq_pkg::torq_stat_type stat
);
   import torq_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_COMMIT} state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:   cmd.capture   = req_tvalid;
         S_SCAN:   cmd.scan_read = 1'b1;
         S_DRAIN:  cmd           = '0;
         S_COMMIT: cmd.commit    = out_free;
         default:  cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (stat.last_slot) state_ff <= S_DRAIN;
            end
            S_DRAIN: begin
               state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: src/torq_dp.sv
// ----------------------------------------------------------------------------
// Time-ordered ready queue datapath
// Slot memory, valid bits, scheduler state, scan unit and result register.
// ----------------------------------------------------------------------------
module torq_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  torq_pkg::torq_cmd_type                cmd,
   output torq_pkg::torq_stat_type               stat,
   input  logic [torq_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  logic [torq_pkg::REQ_USER_BITS-1:0]    req_tuser,
   output logic [torq_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   output logic [torq_pkg::RSP_USER_BITS-1:0]    rsp_tuser
);
   import torq_pkg::*;

   logic [TIME_BITS-1:0] slot_time_mem [CAPACITY];
   logic [ID_BITS-1:0]   slot_id_mem   [CAPACITY];
   logic [CAPACITY-1:0]  slot_valid_ff, slot_valid_in;

   logic [OP_BITS-1:0]   op_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [TIME_BITS-1:0] rtime_ff, dur_ff;
   logic                 died_ff;

   logic [SLOT_BITS-1:0] scan_idx_ff;
   logic                 rd_live_ff;
   logic [TIME_BITS-1:0] rd_time_ff;
   logic [ID_BITS-1:0]   rd_id_ff;
   logic                 rd_valid_ff;
   logic [SLOT_BITS-1:0] rd_idx_ff;

   logic                 best_found_ff, free_found_ff;
   logic [SLOT_BITS-1:0] best_idx_ff, free_idx_ff;
   logic [TIME_BITS-1:0] best_time_ff;
   logic [ID_BITS-1:0]   best_id_ff;
   logic                 cand;

   logic [TIME_BITS-1:0] clock_ff, clock_in;
   logic [ID_BITS-1:0]   cur_id_ff, cur_id_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   logic [ST_BITS-1:0]   status_ff, status_in;
   logic [ID_BITS-1:0]   cid_ff, cid_in;
   logic [TIME_BITS-1:0] ctime_ff, ctime_in;

   logic                 wr_en;
   logic [TIME_BITS-1:0] wr_time;
   logic [ID_BITS-1:0]   wr_id;
   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS-1:0] sat_time;
   logic [CNT_BITS:0]    occupied;
   logic                 full;

   assign stat.last_slot = (scan_idx_ff == SLOT_BITS'(CAPACITY - 1));

   assign cand = rd_valid_ff && ((op_ff != OP_REMOVE) || (rd_id_ff == id_ff));

   // capture request, step scan, collect best and first free slot
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_tuser[OP_BITS-1:0];
         id_ff       <= ID_BITS'(req_tdata[EXT_ID_BITS-1:0]);
         rtime_ff    <= req_tdata[EXT_ID_BITS +: TIME_BITS];
         dur_ff      <= req_tdata[EXT_ID_BITS + TIME_BITS +: TIME_BITS];
         died_ff     <= req_tdata[EXT_ID_BITS + 2 * TIME_BITS];
         scan_idx_ff <= '0;
      end else if (cmd.scan_read) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      if (rd_live_ff) begin
         if (cand && (!best_found_ff ||
                      earlier(rd_time_ff, rd_id_ff, best_time_ff, best_id_ff))) begin
            best_idx_ff  <= rd_idx_ff;
            best_time_ff <= rd_time_ff;
            best_id_ff   <= rd_id_ff;
         end
         if (!rd_valid_ff && !free_found_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan_read;
         if (cmd.capture) begin
            best_found_ff <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (rd_live_ff) begin
            if (cand) best_found_ff <= 1'b1;
            if (!rd_valid_ff) free_found_ff <= 1'b1;
         end
      end
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         slot_time_mem[free_idx_ff] <= wr_time;
         slot_id_mem[free_idx_ff]   <= wr_id;
      end
      if (cmd.scan_read) begin
         rd_time_ff  <= slot_time_mem[scan_idx_ff];
         rd_id_ff    <= slot_id_mem[scan_idx_ff];
         rd_valid_ff <= slot_valid_ff[scan_idx_ff];
         rd_idx_ff   <= scan_idx_ff;
      end
   end

   assign sum      = {1'b0, clock_ff} + {1'b0, dur_ff};
   assign sat_time = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
   assign occupied = {1'b0, count_ff} + (CNT_BITS + 1)'(cur_valid_ff);
   assign full     = (occupied >= (CNT_BITS + 1)'(CAPACITY));

   always_comb begin
      status_in     = ST_OK;
      cid_in        = '0;
      ctime_in      = '0;
      clock_in      = clock_ff;
      cur_id_in     = cur_id_ff;
      cur_valid_in  = cur_valid_ff;
      count_in      = count_ff;
      slot_valid_in = slot_valid_ff;
      wr_en         = 1'b0;
      wr_time       = rtime_ff;
      wr_id         = id_ff;
      case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en                      = 1'b1;
               slot_valid_in[free_idx_ff] = 1'b1;
               count_in                   = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!best_found_ff) begin
               status_in = ST_NOTFOUND;
            end else begin
               slot_valid_in[best_idx_ff] = 1'b0;
               count_in                   = count_ff - 1'b1;
            end
         end
         OP_DISPATCH: begin
            if (cur_valid_ff) begin
               cid_in   = cur_id_ff;
               ctime_in = clock_ff;
            end else if (!best_found_ff) begin
               status_in = ST_EMPTY;
            end else begin
               slot_valid_in[best_idx_ff] = 1'b0;
               count_in                   = count_ff - 1'b1;
               cur_id_in                  = best_id_ff;
               cur_valid_in               = 1'b1;
               clock_in                   = best_time_ff;
               cid_in                     = best_id_ff;
               ctime_in                   = best_time_ff;
            end
         end
         default: begin
            if (!cur_valid_ff) begin
               status_in = ST_NOCUR;
            end else begin
               cid_in = cur_id_ff;
               if (died_ff) begin
                  cur_valid_in = 1'b0;
               end else if (dur_ff == '0) begin
                  ctime_in = clock_ff;
               end else begin
                  clock_in                   = sat_time;
                  cur_valid_in               = 1'b0;
                  wr_en                      = 1'b1;
                  wr_time                    = sat_time;
                  wr_id                      = cur_id_ff;
                  slot_valid_in[free_idx_ff] = 1'b1;
                  count_in                   = count_ff + 1'b1;
                  ctime_in                   = sat_time;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         clock_ff      <= '0;
         cur_id_ff     <= '0;
         cur_valid_ff  <= 1'b0;
         count_ff      <= '0;
      end else if (cmd.commit) begin
         slot_valid_ff <= slot_valid_in;
         clock_ff      <= clock_in;
         cur_id_ff     <= cur_id_in;
         cur_valid_ff  <= cur_valid_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         cid_ff    <= cid_in;
         ctime_ff  <= ctime_in;
      end
   end

   assign rsp_tuser = status_ff;
   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, COUNT_OUT_BITS'(count_ff), clock_ff,
                       ctime_ff, EXT_ID_BITS'(cid_ff)};

endmodule

FILE: src/time_ordered_ready_queue.sv
// ----------------------------------------------------------------------------
// Time-ordered ready queue
// Bounded scheduler table ordered by ready time, then entity id.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req_     in         tuser: operation; tdata: entity_id, ready_time,
//                      action_duration, entity_died
//  rsp_     out        tuser: status; tdata: chosen_id, chosen_time,
//                      clock_now, entry_count
//
//  A request holds the block through the transfer, a scan of one slot per
//  cycle through the single slot memory read port, a drain of the last read
//  and a commit, which waits while the previous result is unaccepted; the
//  result is registered at the commit.
//  A new request transfers while the previous result waits on rsp_tready.
//  Reset empties the table, zeroes the clock and drops the current entity.
// ----------------------------------------------------------------------------
module time_ordered_ready_queue (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // entity_id[7:0], ready_time[39:8], action_duration[71:40], entity_died[72]
   input  logic [torq_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // operation[1:0]
   input  logic [torq_pkg::REQ_USER_BITS-1:0]    req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // chosen_id[7:0], chosen_time[39:8], clock_now[71:40], entry_count[76:72]
   output logic [torq_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // status[2:0]
   output logic [torq_pkg::RSP_USER_BITS-1:0]    rsp_tuser
);
   import torq_pkg::*;

   torq_cmd_type  cmd;
   torq_stat_type stat;

   torq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   torq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

FILE: src/torq_checker.sv
// ----------------------------------------------------------------------------
// Time-ordered ready queue checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "time_ordered_ready_queue_defines.svh"

module torq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [torq_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input logic [torq_pkg::RSP_USER_BITS-1:0]    rsp_tuser
);
   import torq_pkg::*;

   `TORQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   `TORQ_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while scan in progress")

   `TORQ_ASSERT_NOW(a_error_fields_zero, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tdata[39:0] == '0, "error result carries entity data")

   `TORQ_ASSERT_NOW(a_empty_count_zero, clock, reset, rsp_tvalid && (rsp_tuser == ST_EMPTY), rsp_tdata[76:72] == '0, "empty status with nonzero count")

endmodule

bind time_ordered_ready_queue torq_checker u_torq_checker (.*);

FILE: sim/time_ordered_ready_queue_tb.sv
// ----------------------------------------------------------------------------
// Time-ordered ready queue testbench
// A short directed table covers each operation, the ok, empty, no-current
// and not-found codes, ties, duplicate ids and clock saturation. Random
// traffic follows in phases that fill, drain or mix the table. Both channels
// stall at random, the response side holds off for a long stretch, and every
// response is compared to a fixed expectation or an in-bench scheduler model.
// ----------------------------------------------------------------------------
module time_ordered_ready_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import torq_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int HOLD_CYCLES  = 150;
   localparam int TAIL_CYCLES  = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 27;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] rt;
      logic [TIME_BITS-1:0] dur;
      logic                 died;
   } req_type;

   typedef struct packed {
      logic [ST_BITS-1:0]        status;
      logic [EXT_ID_BITS-1:0]    cid;
      logic [TIME_BITS-1:0]      ctime;
      logic [TIME_BITS-1:0]      clk;
      logic [COUNT_OUT_BITS-1:0] count;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    fixed;
      rsp_type want;
   } row_type;

   localparam rsp_type NO_WANT = '0;

   localparam row_type PLAN [24] = '{
      '{'{OP_DISPATCH, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
        '{ST_EMPTY,    8'd0, 32'h0, 32'h0, 5'd0}},
      '{'{OP_COMPLETE, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b1,
        '{ST_NOCUR,    8'd0, 32'h0, 32'h0, 5'd0}},
      '{'{OP_REMOVE,   8'd5,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
        '{ST_NOTFOUND, 8'd0, 32'h0, 32'h0, 5'd0}},
      '{'{OP_INSERT,   8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1,
        '{ST_OK,       8'd0, 32'h0, 32'h0, 5'd1}},
      '{'{OP_INSERT,   8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b1,
        '{ST_OK,       8'd0, 32'h0, 32'h0, 5'd2}},
      '{'{OP_INSERT,   8'd7,   32'h0001_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_INSERT,   8'd3,   32'h0001_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_INSERT,   8'd7,   32'h0000_8000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_REMOVE,   8'd7,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_DISPATCH, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_DISPATCH, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_COMPLETE, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_COMPLETE, 8'd0,   32'h0000_0000, 32'h0002_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_REMOVE,   8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_DISPATCH, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_COMPLETE, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b1}, 1'b0, NO_WANT},
      '{'{OP_DISPATCH, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_COMPLETE, 8'd0,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_DISPATCH, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_REMOVE,   8'd7,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_COMPLETE, 8'd0,   32'h0000_0000, 32'h0000_1234, 1'b1}, 1'b0, NO_WANT},
      '{'{OP_DISPATCH, 8'd0,   32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_COMPLETE, 8'd0,   32'h0000_0000, 32'h0000_0005, 1'b0}, 1'b0, NO_WANT},
      '{'{OP_REMOVE,   8'd255, 32'h0000_0000, 32'h0000_0000, 1'b0}, 1'b0, NO_WANT}
   };

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [REQ_USER_BITS-1:0] req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;

   // scheduler model state
   bit [TIME_BITS-1:0] tbl_time [CAPACITY];
   bit [ID_BITS-1:0]   tbl_id   [CAPACITY];
   bit                 tbl_used [CAPACITY];
   bit [TIME_BITS-1:0] sim_clock;
   bit [ID_BITS-1:0]   cur_id;
   bit                 cur_valid;

   rsp_type pending_outcomes [$];
   int      mismatches;
   int      strays;
   int      cycles;
   int      op_seen [4];
   int      st_seen [8];
   bit      calm;
   bit      hold_asked;

   time_ordered_ready_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_outcomes.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic int table_count();
      int n;
      n = 0;
      for (int i = 0; i < CAPACITY; i++)
         if (tbl_used[i]) n++;
      return n;
   endfunction

   function automatic int table_earliest(input bit match, input bit [ID_BITS-1:0] id);
      int best;
      best = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (!tbl_used[i] || (match && tbl_id[i] != id)) continue;
         if (best < 0 || tbl_time[i] < tbl_time[best] ||
             (tbl_time[i] == tbl_time[best] && tbl_id[i] < tbl_id[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic void table_put(input bit [TIME_BITS-1:0] t,
                                     input bit [ID_BITS-1:0] id);
      for (int i = 0; i < CAPACITY; i++) begin
         if (!tbl_used[i]) begin
            tbl_used[i] = 1'b1;
            tbl_time[i] = t;
            tbl_id[i]   = id;
            return;
         end
      end
   endfunction

   function automatic rsp_type schedule_outcome(input req_type r);
      rsp_type            o;
      int                 k;
      logic [TIME_BITS:0] sum;
      o = '0;
      o.status = ST_OK;
      case (r.op)
         OP_INSERT: begin
            if (table_count() + int'(cur_valid) >= CAPACITY) o.status = ST_FULL;
            else table_put(r.rt, r.id);
         end
         OP_REMOVE: begin
            k = table_earliest(1'b1, r.id);
            if (k < 0) o.status = ST_NOTFOUND;
            else tbl_used[k] = 1'b0;
         end
         OP_DISPATCH: begin
            if (!cur_valid) begin
               k = table_earliest(1'b0, '0);
               if (k < 0) begin
                  o.status = ST_EMPTY;
               end else begin
                  tbl_used[k] = 1'b0;
                  cur_id      = tbl_id[k];
                  cur_valid   = 1'b1;
                  sim_clock   = tbl_time[k];
               end
            end
            if (o.status == ST_OK) begin
               o.cid   = cur_id;
               o.ctime = sim_clock;
            end
         end
         default: begin
            if (!cur_valid) begin
               o.status = ST_NOCUR;
            end else begin
               o.cid = cur_id;
               if (r.died) begin
                  cur_valid = 1'b0;
               end else if (r.dur == '0) begin
                  o.ctime = sim_clock;
               end else begin
                  sum       = {1'b0, sim_clock} + {1'b0, r.dur};
                  sim_clock = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                  cur_valid = 1'b0;
                  table_put(sim_clock, cur_id);
                  o.ctime = sim_clock;
               end
            end
         end
      endcase
      o.clk   = sim_clock;
      o.count = COUNT_OUT_BITS'(table_count());
      return o;
   endfunction

   task automatic offer(input req_type r, input bit fixed, input rsp_type want);
      rsp_type predicted;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= REQ_DATA_BITS'({r.died, r.dur, r.rt, r.id});
      do @(posedge clock); while (!req_tready);
      predicted = schedule_outcome(r);
      pending_outcomes.push_back(fixed ? want : predicted);
      op_seen[r.op]++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // response side: check, then pick next ready
   initial begin
      rsp_type got;
      rsp_type want;
      int      hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[39:8], rsp_tdata[71:40],
                    rsp_tdata[76:72]};
            st_seen[got.status]++;
            if (pending_outcomes.size() == 0) begin
               strays++;
               if (mismatches + strays <= REPORT_MAX)
                  $display("unexpected transfer: status %0d id %0d time %h clock %h count %0d",
                           got.status, got.cid, got.ctime, got.clk, got.count);
            end else begin
               want = pending_outcomes.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches + strays <= REPORT_MAX)
                     $display({"mismatch (exp/got): status %0d/%0d id %0d/%0d ",
                               "time %h/%h clock %h/%h count %0d/%0d"},
                              want.status, got.status, want.cid, got.cid,
                              want.ctime, got.ctime, want.clk, got.clk,
                              want.count, got.count);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_asked) begin
            hold_asked = 1'b0;
            hold_left  = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // request side: directed table, then random phases
   initial begin
      req_type r;
      int      phase;
      int      roll;
      int      used [$];
      logic [TIME_BITS:0] sum;
      phase = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[i])
         offer(PLAN[i].req, PLAN[i].fixed, PLAN[i].want);
      wait_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) phase = $urandom_range(2);
         calm = (n >= 700 && n < 1000);
         if (n == 300) hold_asked = 1'b1;
         if (n == 1300) wait_drained();

         used.delete();
         for (int i = 0; i < CAPACITY; i++)
            if (tbl_used[i]) used.push_back(i);

         roll = $urandom_range(99);
         case (phase)
            0:       r.op = roll < 70 ? OP_INSERT : roll < 80 ? OP_REMOVE :
                            roll < 90 ? OP_DISPATCH : OP_COMPLETE;
            1:       r.op = roll < 15 ? OP_INSERT : roll < 30 ? OP_REMOVE :
                            roll < 65 ? OP_DISPATCH : OP_COMPLETE;
            default: r.op = roll < 30 ? OP_INSERT : roll < 45 ? OP_REMOVE :
                            roll < 70 ? OP_DISPATCH : OP_COMPLETE;
         endcase

         r.id = ($urandom_range(99) < 70) ? ID_BITS'($urandom_range(15))
                                          : ID_BITS'($urandom);
         roll = $urandom_range(99);
         if (r.op == OP_REMOVE && used.size() != 0 && roll < 70)
            r.id = tbl_id[used[$urandom_range(used.size() - 1)]];
         else if (r.op == OP_REMOVE && roll < 80)
            r.id = cur_id;

         roll = $urandom_range(99);
         if (roll < 35) begin
            sum  = {1'b0, sim_clock} + (TIME_BITS + 1)'($urandom_range('h40000));
            r.rt = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
         end else if (roll < 55) begin
            r.rt = $urandom;
         end else if (roll < 65) begin
            r.rt = '0;
         end else if (roll < 75) begin
            r.rt = '1;
         end else begin
            r.rt = (used.size() != 0) ? tbl_time[used[$urandom_range(used.size() - 1)]]
                                      : sim_clock;
         end

         roll = $urandom_range(99);
         if (roll < 15)      r.dur = '0;
         else if (roll < 65) r.dur = $urandom_range('h30000, 1);
         else if (roll < 85) r.dur = $urandom;
         else if (roll < 92) r.dur = '1;
         else                r.dur = $urandom | 32'h8000_0000;

         r.died = ($urandom_range(99) < 15);
         offer(r, 1'b0, NO_WANT);
      end

      calm = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d transfers: %0d insert, %0d remove, %0d dispatch, %0d complete",
               op_seen[OP_INSERT] + op_seen[OP_REMOVE] + op_seen[OP_DISPATCH] +
               op_seen[OP_COMPLETE], op_seen[OP_INSERT], op_seen[OP_REMOVE],
               op_seen[OP_DISPATCH], op_seen[OP_COMPLETE]);
      $display("results: %0d ok, %0d empty, %0d full, %0d not found, %0d no current",
               st_seen[ST_OK], st_seen[ST_EMPTY], st_seen[ST_FULL],
               st_seen[ST_NOTFOUND], st_seen[ST_NOCUR]);
      if (mismatches == 0 && strays == 0 && pending_outcomes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d unexpected transfers", mismatches, strays);
         $display("status: fail");
      end
      $finish;
   end

endmodule
